// File: design/mexp_pkg.sv
`default_nettype none

package mexp_pkg;

  localparam int FIELD_W = 31;
  localparam int WIDTH_DEF = 32;
  localparam int ADDR_W = 5;
  localparam int ACT_W = 4;
  localparam int COND_W = 4;

  typedef struct packed {
    logic [FIELD_W-1:0] base;
    logic [FIELD_W-1:0] exponent;
    logic [FIELD_W-1:0] modulus;
  } in_t;

  typedef struct packed {
    logic [FIELD_W-1:0] power;
    logic               is_one;
    logic               bad_modulus;
  } out_t;

  // Datapath actions, one per control word.
  localparam logic [ACT_W-1:0] ACT_NONE      = 4'd0;
  localparam logic [ACT_W-1:0] ACT_LOAD      = 4'd1;
  localparam logic [ACT_W-1:0] ACT_START_RED = 4'd2;
  localparam logic [ACT_W-1:0] ACT_START_SQR = 4'd3;
  localparam logic [ACT_W-1:0] ACT_START_MUL = 4'd4;
  localparam logic [ACT_W-1:0] ACT_WB_BASE   = 4'd5;
  localparam logic [ACT_W-1:0] ACT_WB_ACC    = 4'd6;
  localparam logic [ACT_W-1:0] ACT_NEXT_BIT  = 4'd7;
  localparam logic [ACT_W-1:0] ACT_EMIT_ACC  = 4'd8;
  localparam logic [ACT_W-1:0] ACT_EMIT_BAD  = 4'd9;
  localparam logic [ACT_W-1:0] ACT_EMIT_ONE  = 4'd10;

  // Jump conditions; when false the step counter simply advances.
  localparam logic [COND_W-1:0] COND_NEVER     = 4'd0;
  localparam logic [COND_W-1:0] COND_ALWAYS    = 4'd1;
  localparam logic [COND_W-1:0] COND_NO_INPUT  = 4'd2;
  localparam logic [COND_W-1:0] COND_BAD_MOD   = 4'd3;
  localparam logic [COND_W-1:0] COND_EXP_ZERO  = 4'd4;
  localparam logic [COND_W-1:0] COND_MUL_BUSY  = 4'd5;
  localparam logic [COND_W-1:0] COND_BIT_CLEAR = 4'd6;
  localparam logic [COND_W-1:0] COND_MORE_BITS = 4'd7;
  localparam logic [COND_W-1:0] COND_OUT_BUSY  = 4'd8;

  // Program addresses.
  localparam logic [ADDR_W-1:0] A_IDLE     = 5'd0;
  localparam logic [ADDR_W-1:0] A_CHK_MOD  = 5'd1;
  localparam logic [ADDR_W-1:0] A_CHK_EXP  = 5'd2;
  localparam logic [ADDR_W-1:0] A_RED      = 5'd3;
  localparam logic [ADDR_W-1:0] A_RED_WAIT = 5'd4;
  localparam logic [ADDR_W-1:0] A_RED_WB   = 5'd5;
  localparam logic [ADDR_W-1:0] A_SQR      = 5'd6;
  localparam logic [ADDR_W-1:0] A_SQR_WAIT = 5'd7;
  localparam logic [ADDR_W-1:0] A_SQR_WB   = 5'd8;
  localparam logic [ADDR_W-1:0] A_MUL      = 5'd9;
  localparam logic [ADDR_W-1:0] A_MUL_WAIT = 5'd10;
  localparam logic [ADDR_W-1:0] A_MUL_WB   = 5'd11;
  localparam logic [ADDR_W-1:0] A_NEXT     = 5'd12;
  localparam logic [ADDR_W-1:0] A_EMIT     = 5'd13;
  localparam logic [ADDR_W-1:0] A_EMIT_RET = 5'd14;
  localparam logic [ADDR_W-1:0] A_BAD      = 5'd15;
  localparam logic [ADDR_W-1:0] A_BAD_RET  = 5'd16;
  localparam logic [ADDR_W-1:0] A_ONE      = 5'd17;
  localparam logic [ADDR_W-1:0] A_ONE_RET  = 5'd18;

  typedef struct packed {
    logic [ACT_W-1:0]  act;
    logic [COND_W-1:0] cond;
    logic [ADDR_W-1:0] target;
  } ucode_t;

  typedef struct packed {
    logic no_input;
    logic bad_mod;
    logic exp_zero;
    logic mul_busy;
    logic bit_clear;
    logic more_bits;
    logic out_busy;
  } stat_t;

  function automatic ucode_t uword(logic [ACT_W-1:0] act, logic [COND_W-1:0] cond,
                                   logic [ADDR_W-1:0] target);
    ucode_t w;
    w.act = act;
    w.cond = cond;
    w.target = target;
    return w;
  endfunction

  function automatic ucode_t ucode_rom(logic [ADDR_W-1:0] addr);
    ucode_t w;
    case (addr)
      A_IDLE:     w = uword(ACT_LOAD,      COND_NO_INPUT,  A_IDLE);
      A_CHK_MOD:  w = uword(ACT_NONE,      COND_BAD_MOD,   A_BAD);
      A_CHK_EXP:  w = uword(ACT_NONE,      COND_EXP_ZERO,  A_ONE);
      A_RED:      w = uword(ACT_START_RED, COND_NEVER,     A_IDLE);
      A_RED_WAIT: w = uword(ACT_NONE,      COND_MUL_BUSY,  A_RED_WAIT);
      A_RED_WB:   w = uword(ACT_WB_BASE,   COND_NEVER,     A_IDLE);
      A_SQR:      w = uword(ACT_START_SQR, COND_NEVER,     A_IDLE);
      A_SQR_WAIT: w = uword(ACT_NONE,      COND_MUL_BUSY,  A_SQR_WAIT);
      A_SQR_WB:   w = uword(ACT_WB_ACC,    COND_BIT_CLEAR, A_NEXT);
      A_MUL:      w = uword(ACT_START_MUL, COND_NEVER,     A_IDLE);
      A_MUL_WAIT: w = uword(ACT_NONE,      COND_MUL_BUSY,  A_MUL_WAIT);
      A_MUL_WB:   w = uword(ACT_WB_ACC,    COND_NEVER,     A_IDLE);
      A_NEXT:     w = uword(ACT_NEXT_BIT,  COND_MORE_BITS, A_SQR);
      A_EMIT:     w = uword(ACT_EMIT_ACC,  COND_OUT_BUSY,  A_EMIT);
      A_EMIT_RET: w = uword(ACT_NONE,      COND_ALWAYS,    A_IDLE);
      A_BAD:      w = uword(ACT_EMIT_BAD,  COND_OUT_BUSY,  A_BAD);
      A_BAD_RET:  w = uword(ACT_NONE,      COND_ALWAYS,    A_IDLE);
      A_ONE:      w = uword(ACT_EMIT_ONE,  COND_OUT_BUSY,  A_ONE);
      A_ONE_RET:  w = uword(ACT_NONE,      COND_ALWAYS,    A_IDLE);
      default:    w = uword(ACT_NONE,      COND_ALWAYS,    A_IDLE);
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// File: design/mexp_mulmod.sv
`default_nettype none

module mexp_mulmod import mexp_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [FIELD_W-1:0] x,
  input  wire logic [FIELD_W-1:0] y,
  input  wire logic [FIELD_W-1:0] m,
  output logic                    busy,
  output logic [FIELD_W-1:0]      prod
);

  localparam int CNT_W = $clog2(FIELD_W + 1);
  localparam int T_W = FIELD_W + 3;

  logic [FIELD_W-1:0] r_r, r_nxt;
  logic [FIELD_W-1:0] x_r;
  logic [FIELD_W-1:0] y_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               busy_r;
  logic [T_W-1:0]     t, d1, d2;

  // Multiplier bits are taken most significant first: r = 2r + bit*x, and since
  // r < m and x < m the sum stays below 3m, so one of two subtractions reduces it.
  always_comb begin
    t = {r_r, 1'b0} + (y_r[FIELD_W-1] ? {3'b000, x_r} : '0);
    d1 = t - {3'b000, m};
    d2 = t - {2'b00, m, 1'b0};
    if (!d2[T_W-1]) begin
      r_nxt = d2[FIELD_W-1:0];
    end else if (!d1[T_W-1]) begin
      r_nxt = d1[FIELD_W-1:0];
    end else begin
      r_nxt = t[FIELD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(FIELD_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      r_r <= '0;
      x_r <= x;
      y_r <= y;
    end else if (busy_r) begin
      r_r <= r_nxt;
      y_r <= {y_r[FIELD_W-2:0], 1'b0};
    end
  end

  assign busy = busy_r;
  assign prod = r_r;

endmodule

`default_nettype wire

// File: design/mexp_seq.sv
`default_nettype none

module mexp_seq import mexp_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire stat_t stat,
  output ucode_t     ctrl
);

  logic [ADDR_W-1:0] step_r, step_nxt;
  logic              jump;

  assign ctrl = ucode_rom(step_r);

  always_comb begin
    case (ctrl.cond)
      COND_NEVER:     jump = 1'b0;
      COND_ALWAYS:    jump = 1'b1;
      COND_NO_INPUT:  jump = stat.no_input;
      COND_BAD_MOD:   jump = stat.bad_mod;
      COND_EXP_ZERO:  jump = stat.exp_zero;
      COND_MUL_BUSY:  jump = stat.mul_busy;
      COND_BIT_CLEAR: jump = stat.bit_clear;
      COND_MORE_BITS: jump = stat.more_bits;
      COND_OUT_BUSY:  jump = stat.out_busy;
      default:        jump = 1'b1;
    endcase
    step_nxt = jump ? ctrl.target : step_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= A_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

`default_nettype wire

// File: design/modular_exponentiation_top.sv
// A transaction scans k = min(WIDTH, 31) exponent bits, squaring once per bit and
// multiplying once more for each of the n bits that are set.
// A zero modulus or a zero exponent is answered without running the multiplier.
// Throughput: one transaction at a time; the next is accepted only after the result
// has been emitted, bounded by the 31-step shift-add modular multiplier.
// Reset: synchronous active-low rst_n returns the sequencer to idle and empties the output.
`default_nettype none

module modular_exponentiation_top import mexp_pkg::*; #(
  parameter int WIDTH = WIDTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire in_t  in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_t      out_data
);

  localparam int SCAN = (WIDTH < FIELD_W) ? WIDTH : FIELD_W;
  localparam int CNT_W = $clog2(SCAN + 1);

  ucode_t             ctrl;
  stat_t              stat;
  logic [FIELD_W-1:0] b_r, b_nxt;
  logic [SCAN-1:0]    e_r, e_nxt;
  logic [FIELD_W-1:0] m_r, m_nxt;
  logic [FIELD_W-1:0] acc_r, acc_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_t               out_data_r, out_data_nxt;
  logic [FIELD_W-1:0] one_red;
  logic               mul_start, mul_busy;
  logic [FIELD_W-1:0] mul_x, mul_y, prod;
  logic               out_busy;

  // One reduced by the modulus: zero only for a modulus of one.
  assign one_red = {{(FIELD_W-1){1'b0}}, (m_r != FIELD_W'(1))};
  assign out_busy = out_valid_r && !out_ready;
  assign in_ready = (ctrl.act == ACT_LOAD);

  assign stat.no_input  = !in_valid;
  assign stat.bad_mod   = (m_r == '0);
  assign stat.exp_zero  = (e_r == '0);
  assign stat.mul_busy  = mul_busy;
  assign stat.bit_clear = !e_r[SCAN-1];
  assign stat.more_bits = (cnt_r != CNT_W'(1));
  assign stat.out_busy  = out_busy;

  mexp_seq u_seq (
    .clk  (clk),
    .rst_n(rst_n),
    .stat (stat),
    .ctrl (ctrl)
  );

  always_comb begin
    mul_start = ctrl.act inside {ACT_START_RED, ACT_START_SQR, ACT_START_MUL};
    case (ctrl.act)
      ACT_START_RED: begin
        // The base is reduced by multiplying it into one reduced by the modulus.
        mul_x = one_red;
        mul_y = b_r;
      end
      ACT_START_SQR: begin
        mul_x = acc_r;
        mul_y = acc_r;
      end
      default: begin
        mul_x = acc_r;
        mul_y = b_r;
      end
    endcase
  end

  mexp_mulmod u_mulmod (
    .clk  (clk),
    .rst_n(rst_n),
    .start(mul_start),
    .x    (mul_x),
    .y    (mul_y),
    .m    (m_r),
    .busy (mul_busy),
    .prod (prod)
  );

  always_comb begin
    b_nxt = b_r;
    e_nxt = e_r;
    m_nxt = m_r;
    acc_nxt = acc_r;
    cnt_nxt = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt = out_data_r;
    case (ctrl.act)
      ACT_LOAD: begin
        if (in_valid) begin
          b_nxt = in_data.base;
          e_nxt = in_data.exponent[SCAN-1:0];
          m_nxt = in_data.modulus;
          cnt_nxt = CNT_W'(SCAN);
        end
      end
      ACT_WB_BASE: begin
        b_nxt = prod;
        acc_nxt = one_red;
      end
      ACT_WB_ACC: begin
        acc_nxt = prod;
      end
      ACT_NEXT_BIT: begin
        e_nxt = e_r << 1;
        cnt_nxt = cnt_r - 1'b1;
      end
      ACT_EMIT_ACC: begin
        if (!out_busy) begin
          out_valid_nxt = 1'b1;
          out_data_nxt.power = acc_r;
          out_data_nxt.is_one = (acc_r == one_red);
          out_data_nxt.bad_modulus = 1'b0;
        end
      end
      ACT_EMIT_BAD: begin
        if (!out_busy) begin
          out_valid_nxt = 1'b1;
          out_data_nxt.power = '0;
          out_data_nxt.is_one = 1'b0;
          out_data_nxt.bad_modulus = 1'b1;
        end
      end
      ACT_EMIT_ONE: begin
        // A zero exponent returns one unreduced, compared against one mod m.
        if (!out_busy) begin
          out_valid_nxt = 1'b1;
          out_data_nxt.power = FIELD_W'(1);
          out_data_nxt.is_one = one_red[0];
          out_data_nxt.bad_modulus = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    b_r <= b_nxt;
    e_r <= e_nxt;
    m_r <= m_nxt;
    acc_r <= acc_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

endmodule

`default_nettype wire

// File: design/mexp_checker.sv
`default_nettype none

module mexp_checker import mexp_pkg::*; (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire out_t out_data
);

  // A result that is not taken stays put.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Only one transaction is in flight: acceptance closes the input.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input reopened straight after acceptance");

  // A new result never appears while the input is open.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !in_ready)
    else $error("result appeared while idle");

  // The error result carries zero power and no witness flag.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.bad_modulus |-> out_data.power == '0 && !out_data.is_one)
    else $error("bad modulus result not cleared");

endmodule

bind modular_exponentiation_top mexp_checker u_mexp_checker (.*);

`default_nettype wire
